// File: rtl/core/mcme_pkg.sv
// Package for the masked cost matrix engine.
// Holds the action codes and the sequencer state type; no dependencies.
package mcme_pkg;

  typedef enum logic [3:0] {
    ACT_WR_ENTRY = 4'd0,
    ACT_SET_ROW  = 4'd1,
    ACT_SET_COL  = 4'd2,
    ACT_ROW_MARK = 4'd3,
    ACT_COL_MARK = 4'd4,
    ACT_ROW_MIN  = 4'd5,
    ACT_COL_MIN  = 4'd6,
    ACT_SUB_ROW  = 4'd7,
    ACT_SUB_COL  = 4'd8,
    ACT_ADD_ROW  = 4'd9,
    ACT_ADD_COL  = 4'd10,
    ACT_ZERO     = 4'd11
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_e;

  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

endpackage

// File: rtl/core/mcme_alu.sv
// Shared cost unit: one compare, subtract or saturating add per cycle.
// Depends on mcme_pkg for the action codes.
module mcme_alu import mcme_pkg::*; #(
  parameter int unsigned COST_WIDTH = 32
) (
  input  action_e               action_i,
  input  logic [COST_WIDTH-1:0] entry_i,
  input  logic [COST_WIDTH-1:0] operand_i,
  input  logic                  masked_i,
  input  logic [COST_WIDTH-1:0] best_i,
  output logic [COST_WIDTH-1:0] result_o,
  output logic                  better_o,
  output logic                  nonzero_o
);

  localparam logic [COST_WIDTH-1:0] Inf = '1;
  logic [COST_WIDTH:0] sum;

  assign sum = {1'b0, entry_i} + {1'b0, operand_i};
  assign better_o = !masked_i && (entry_i < best_i);
  assign nonzero_o = !masked_i && (entry_i != '0);

  always_comb begin
    unique case (action_i)
      ACT_SUB_ROW, ACT_SUB_COL: begin
        if (masked_i) result_o = '0;
        else if (entry_i == Inf && operand_i != Inf) result_o = Inf;
        else result_o = entry_i - operand_i;
      end
      ACT_ADD_ROW, ACT_ADD_COL: begin
        if (sum[COST_WIDTH] || sum[COST_WIDTH-1:0] == Inf) result_o = Inf;
        else result_o = sum[COST_WIDTH-1:0];
      end
      default: result_o = operand_i;
    endcase
  end

endmodule

// File: rtl/core/masked_cost_matrix_engine.sv
// Top level of the masked cost matrix engine: sequencer, store and marks.
// Depends on mcme_pkg and mcme_alu.
//
// Usage: an action is transferred when start_i is high and busy_o is low.
// The block walks the addressed row or column, or the whole matrix for the
// zero test, one entry at a time through a single-port store with registered
// read data and the shared cost unit. Each entry passes a read state, then
// an evaluate-and-write-back state; single-entry, mark and error actions go
// from the read state straight to the done state.
// Exactly one result per action appears for one cycle with valid_o high;
// the receiver cannot stall it.
// After reset a clearing pass writes zero to all MAX_ROWS*MAX_COLS entries,
// one per cycle, with busy_o high; configuration writes are taken meanwhile.
// Counts reset to 16 (clamped to the maximum); cfg_we_i writes a count,
// 0 is taken as 1 and values above the maximum as the maximum.
module masked_cost_matrix_engine import mcme_pkg::*; #(
  parameter int unsigned MAX_ROWS   = 16,
  parameter int unsigned MAX_COLS   = 16,
  parameter int unsigned COST_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  action_i,
  input  logic [3:0]  row_sel_i,
  input  logic [3:0]  col_sel_i,
  input  logic [31:0] operand_value_i,
  input  logic        mark_bit_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  output logic        valid_o,
  output logic [31:0] min_cost_o,
  output logic [3:0]  min_position_o,
  output logic        all_zero_o,
  output logic        index_error_o
);

  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW = $clog2(MAX_COLS + 1);
  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [COST_WIDTH-1:0] Inf = '1;

  state_e state_q, state_d;
  logic [RCW-1:0] row_count_q;
  logic [CCW-1:0] col_count_q;
  logic [MAX_ROWS-1:0] row_del_q;
  logic [MAX_COLS-1:0] col_del_q;
  action_e act_q;
  logic [5:0] r_q, c_q;
  logic [COST_WIDTH-1:0] opv_q, best_q, rdata_q;
  logic [5:0] pos_q, i_q, j_q;
  logic zero_q, err_q;
  logic [AW:0] clr_q;
  logic [COST_WIDTH-1:0] mem [DEPTH];

  logic is_row, is_col, need_row, need_col, bad, masked, last;
  logic [5:0] rr, cc;
  logic [AW-1:0] addr;
  logic we;
  logic [COST_WIDTH-1:0] wdata, alu_res;
  logic better, nonzero;
  logic [4:0] clamp_r, clamp_c;

  assign is_row = act_q == ACT_SET_ROW || act_q == ACT_ROW_MIN ||
                  act_q == ACT_SUB_ROW || act_q == ACT_ADD_ROW;
  assign is_col = act_q == ACT_SET_COL || act_q == ACT_COL_MIN ||
                  act_q == ACT_SUB_COL || act_q == ACT_ADD_COL;
  assign need_row = is_row || act_q == ACT_WR_ENTRY || act_q == ACT_ROW_MARK;
  assign need_col = is_col || act_q == ACT_WR_ENTRY || act_q == ACT_COL_MARK;
  assign bad = (need_row && {2'b0, r_q} >= 8'(row_count_q)) ||
               (need_col && {2'b0, c_q} >= 8'(col_count_q));

  always_comb begin
    rr = is_row ? r_q : i_q;
    cc = is_col ? c_q : j_q;
    if (act_q == ACT_WR_ENTRY) begin
      rr = r_q;
      cc = c_q;
    end
  end
  assign addr = AW'(32'(rr[RW-1:0]) * MAX_COLS + 32'(cc[CW-1:0]));
  assign masked = (act_q == ACT_ROW_MIN || act_q == ACT_SUB_ROW || act_q == ACT_ZERO)
                  && col_del_q[cc[CW-1:0]] ||
                  (act_q == ACT_COL_MIN || act_q == ACT_SUB_COL || act_q == ACT_ZERO)
                  && row_del_q[rr[RW-1:0]];

  always_comb begin
    last = 1'b1;
    if (is_row) last = 8'(j_q) + 8'd1 >= 8'(col_count_q);
    else if (is_col) last = 8'(i_q) + 8'd1 >= 8'(row_count_q);
    else if (act_q == ACT_ZERO)
      last = 8'(j_q) + 8'd1 >= 8'(col_count_q) && 8'(i_q) + 8'd1 >= 8'(row_count_q);
  end

  mcme_alu #(.COST_WIDTH(COST_WIDTH)) u_alu (
    .action_i (act_q),
    .entry_i  (rdata_q),
    .operand_i(opv_q),
    .masked_i (masked),
    .best_i   (best_q),
    .result_o (alu_res),
    .better_o (better),
    .nonzero_o(nonzero)
  );

  always_comb begin
    state_d = state_q;
    we = 1'b0;
    wdata = alu_res;
    unique case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        wdata = '0;
        if (clr_q == (AW + 1)'(DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: if (start_i) state_d = ST_READ;
      ST_READ: begin
        if (bad || act_q == ACT_WR_ENTRY || act_q == ACT_ROW_MARK ||
            act_q == ACT_COL_MARK || act_q > ACT_ZERO) begin
          we = !bad && act_q == ACT_WR_ENTRY;
          state_d = ST_DONE;
        end else state_d = ST_EVAL;
      end
      ST_EVAL: begin
        we = act_q != ACT_ROW_MIN && act_q != ACT_COL_MIN && act_q != ACT_ZERO;
        state_d = last ? ST_DONE : ST_READ;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[state_q == ST_CLEAR ? clr_q[AW-1:0] : addr] <= wdata;
    rdata_q <= mem[addr];
  end

  assign clamp_r = (cfg_data_i == 5'd0) ? 5'd1 :
                   (32'(cfg_data_i) > MAX_ROWS) ? 5'(MAX_ROWS) : cfg_data_i;
  assign clamp_c = (cfg_data_i == 5'd0) ? 5'd1 :
                   (32'(cfg_data_i) > MAX_COLS) ? 5'(MAX_COLS) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      row_count_q <= RCW'((MAX_ROWS < 16) ? MAX_ROWS : 16);
      col_count_q <= CCW'((MAX_COLS < 16) ? MAX_COLS : 16);
      row_del_q <= '0;
      col_del_q <= '0;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_o <= state_q == ST_DONE;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_we_i && cfg_index_i == CFG_ROW_COUNT) row_count_q <= RCW'(clamp_r);
      if (cfg_we_i && cfg_index_i == CFG_COL_COUNT) col_count_q <= CCW'(clamp_c);
      if (state_q == ST_READ && !bad) begin
        if (act_q == ACT_ROW_MARK) row_del_q[r_q[RW-1:0]] <= opv_q[0];
        if (act_q == ACT_COL_MARK) col_del_q[c_q[CW-1:0]] <= opv_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      act_q <= action_e'(action_i);
      r_q <= {2'b0, row_sel_i};
      c_q <= {2'b0, col_sel_i};
      opv_q <= (action_i == ACT_ROW_MARK || action_i == ACT_COL_MARK) ?
               COST_WIDTH'(mark_bit_i) : COST_WIDTH'(operand_value_i);
      best_q <= Inf;
      pos_q <= '0;
      zero_q <= 1'b1;
      i_q <= '0;
      j_q <= '0;
    end
    if (state_q == ST_READ) err_q <= bad;
    if (state_q == ST_EVAL) begin
      if (better) begin
        best_q <= rdata_q;
        pos_q <= is_row ? j_q : i_q;
      end
      if (nonzero) zero_q <= 1'b0;
      if (is_row) j_q <= j_q + 6'd1;
      else if (is_col) i_q <= i_q + 6'd1;
      else if (8'(j_q) + 8'd1 >= 8'(col_count_q)) begin
        j_q <= '0;
        i_q <= i_q + 6'd1;
      end else j_q <= j_q + 6'd1;
    end
    if (state_q == ST_DONE) begin
      min_cost_o <= (!err_q && (act_q == ACT_ROW_MIN || act_q == ACT_COL_MIN)) ?
                    32'(best_q) : 32'd0;
      min_position_o <= (!err_q && (act_q == ACT_ROW_MIN || act_q == ACT_COL_MIN)) ?
                        pos_q[3:0] : 4'd0;
      all_zero_o <= !err_q && act_q == ACT_ZERO && zero_q;
      index_error_o <= err_q;
    end
  end

  assign busy_o = state_q != ST_IDLE;

endmodule

// File: rtl/core/mcme_checker.sv
// Port-level checker for the masked cost matrix engine, with its bind.
// Depends on the top level's ports only.
module mcme_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        valid_o,
  input logic [31:0] min_cost_o,
  input logic        all_zero_o,
  input logic        index_error_o
);

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("not busy after transfer");
  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe repeated");
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result while busy");
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && index_error_o |-> min_cost_o == 32'd0 && !all_zero_o)
    else $error("error result carries data");

endmodule

bind masked_cost_matrix_engine mcme_checker u_mcme_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .valid_o(valid_o), .min_cost_o(min_cost_o), .all_zero_o(all_zero_o),
  .index_error_o(index_error_o)
);
